/* hdl/crc32rm_pkg.sv */
// ----------------------------------------------------------------------------
// crc32rm_pkg
// Shared types, constants and GF(2) helpers for the multi-byte CRC-32 core.
// ----------------------------------------------------------------------------
package crc32rm_pkg;

	localparam int CRC_W              = 32;
	localparam int DATA_W             = 64;
	localparam int COUNT_W            = 4;
	localparam int MAX_BYTES          = 16;
	localparam int DEF_BYTES_PER_ITEM = 8;
	localparam int CNT_W              = $clog2(MAX_BYTES + 1);

	localparam logic [CRC_W-1:0] CRC_ALL_ONES  = 32'hFFFF_FFFF;
	localparam logic [CRC_W-1:0] CRC_IEEE_POLY = 32'hEDB8_8320;

	typedef logic [CRC_W-1:0] crc_t;
	// column k holds the image of remainder bit k
	typedef crc_t [CRC_W-1:0] crc_mat_t;

	typedef struct packed {
		logic             first;
		logic             last;
		logic [CNT_W-1:0] count;
	} item_ctrl_t;

	// eight reflected shift steps with a zero data byte
	function automatic crc_t crc_step8(crc_t x, crc_t poly);
		crc_t r;
		r = x;
		for (int k = 0; k < 8; k++) begin
			r = (r >> 1) ^ (r[0] ? poly : '0);
		end
		return r;
	endfunction

	function automatic crc_t crc_mat_apply(crc_mat_t m, crc_t v);
		crc_t acc;
		acc = '0;
		for (int k = 0; k < CRC_W; k++) begin
			if (v[k]) begin
				acc = acc ^ m[k];
			end
		end
		return acc;
	endfunction

	function automatic crc_mat_t crc_identity();
		crc_mat_t m;
		for (int k = 0; k < CRC_W; k++) begin
			m[k] = crc_t'(1) << k;
		end
		return m;
	endfunction

endpackage

/* hdl/crc32rm_item_if.sv */
// ----------------------------------------------------------------------------
// crc32rm_item_if
// Input channel: up to eight message bytes with count and framing flags.
// ----------------------------------------------------------------------------
interface crc32rm_item_if;
	import crc32rm_pkg::*;

	logic               valid;
	logic               ready;
	logic [DATA_W-1:0]  data_bytes;
	logic [COUNT_W-1:0] byte_count;
	logic               first_item;
	logic               last_item;

	modport source (
		output valid, data_bytes, byte_count, first_item, last_item,
		input  ready
	);
	modport sink (
		input  valid, data_bytes, byte_count, first_item, last_item,
		output ready
	);
endinterface

/* hdl/crc32rm_result_if.sv */
// ----------------------------------------------------------------------------
// crc32rm_result_if
// Result channel: running remainder, final CRC and end-of-message flag.
// ----------------------------------------------------------------------------
interface crc32rm_result_if;
	import crc32rm_pkg::*;

	logic             valid;
	logic             ready;
	logic [CRC_W-1:0] running_remainder;
	logic [CRC_W-1:0] final_crc;
	logic             is_final;

	modport source (
		output valid, running_remainder, final_crc, is_final,
		input  ready
	);
	modport sink (
		input  valid, running_remainder, final_crc, is_final,
		output ready
	);
endinterface

/* hdl/crc32rm_mtx_gen.sv */
// ----------------------------------------------------------------------------
// crc32rm_mtx_gen
// Holds the polynomial and builds the n-byte advance matrices, one per cycle.
// ----------------------------------------------------------------------------
module crc32rm_mtx_gen #(
	parameter int BYTES_PER_ITEM = crc32rm_pkg::DEF_BYTES_PER_ITEM
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  poly_we,
	input  crc32rm_pkg::crc_t     poly_wdata,
	output crc32rm_pkg::crc_mat_t mats [BYTES_PER_ITEM+1],
	output logic                  busy
);
	import crc32rm_pkg::*;

	localparam int NW = $clog2(BYTES_PER_ITEM + 1);

	crc_t          poly_q;
	crc_mat_t      work_q;
	crc_mat_t      work_nxt;
	crc_mat_t      tab_q [1:BYTES_PER_ITEM];
	logic [NW-1:0] cnt_q;

	assign busy = (cnt_q != '0);

	always_comb begin
		for (int k = 0; k < CRC_W; k++) begin
			work_nxt[k] = crc_step8(work_q[k], poly_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			poly_q <= CRC_IEEE_POLY;
			work_q <= crc_identity();
			cnt_q  <= NW'(1);
		end else if (poly_we) begin
			poly_q <= poly_wdata;
			work_q <= crc_identity();
			cnt_q  <= NW'(1);
		end else if (busy) begin
			work_q <= work_nxt;
			cnt_q  <= (cnt_q == NW'(BYTES_PER_ITEM)) ? '0 : cnt_q + 1'b1;
		end
	end

	// A_n lands in entry n while the build counter equals n
	always_ff @(posedge clk) begin
		if (busy && !poly_we) begin
			tab_q[cnt_q] <= work_nxt;
		end
	end

	assign mats[0] = crc_identity();

	for (genvar i = 1; i <= BYTES_PER_ITEM; i++) begin : g_mat
		assign mats[i] = tab_q[i];
	end

endmodule

/* hdl/crc32rm_lane.sv */
// ----------------------------------------------------------------------------
// crc32rm_lane
// One byte lane: maps its byte through the lane's advance matrix.
// ----------------------------------------------------------------------------
module crc32rm_lane (
	input  logic                  clk,
	input  logic                  load,
	input  crc32rm_pkg::crc_mat_t mat,
	input  logic [7:0]            lane_byte,
	output crc32rm_pkg::crc_t     contrib_s2
);
	import crc32rm_pkg::*;

	// only the low eight columns matter for a byte
	always_ff @(posedge clk) begin
		if (load) begin
			contrib_s2 <= crc_mat_apply(mat, crc_t'(lane_byte));
		end
	end

endmodule

/* hdl/crc32rm_merge.sv */
// ----------------------------------------------------------------------------
// crc32rm_merge
// Combines lane results and folds them into the running remainder.
// ----------------------------------------------------------------------------
module crc32rm_merge #(
	parameter int BYTES_PER_ITEM = crc32rm_pkg::DEF_BYTES_PER_ITEM
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  crc32rm_pkg::crc_t       lane_c [BYTES_PER_ITEM],
	input  logic                    load_s3,
	input  logic                    load_out,
	input  crc32rm_pkg::item_ctrl_t ctrl_s3,
	input  crc32rm_pkg::crc_mat_t   mats [BYTES_PER_ITEM+1],
	output crc32rm_pkg::crc_t       running_remainder,
	output crc32rm_pkg::crc_t       final_crc,
	output logic                    is_final
);
	import crc32rm_pkg::*;

	localparam int NW = $clog2(BYTES_PER_ITEM + 1);

	crc_t data_c;
	crc_t d_s3;
	crc_t rem_q;
	crc_t rem_in;
	crc_t rem_nxt;
	crc_t final_q;
	logic is_final_q;

	always_comb begin
		data_c = '0;
		for (int j = 0; j < BYTES_PER_ITEM; j++) begin
			data_c = data_c ^ lane_c[j];
		end
	end

	always_ff @(posedge clk) begin
		if (load_s3) begin
			d_s3 <= data_c;
		end
	end

	assign rem_in  = ctrl_s3.first ? CRC_ALL_ONES : rem_q;
	assign rem_nxt = crc_mat_apply(mats[ctrl_s3.count[NW-1:0]], rem_in) ^ d_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q <= CRC_ALL_ONES;
		end else if (load_out) begin
			rem_q <= rem_nxt;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			final_q    <= ctrl_s3.last ? ~rem_nxt : '0;
			is_final_q <= ctrl_s3.last;
		end
	end

	assign running_remainder = rem_q;
	assign final_crc         = final_q;
	assign is_final          = is_final_q;

endmodule

/* hdl/crc32_reflected_multi_byte_core.sv */
// ----------------------------------------------------------------------------
// crc32_reflected_multi_byte_core
// Reflected CRC-32 over up to eight bytes per transfer, programmable polynomial.
// ----------------------------------------------------------------------------
//
//  channel    dir  handshake          payload
//  items      in   valid / ready      data_bytes, byte_count, first_item, last_item
//  results    out  valid / ready      running_remainder, final_crc, is_final
//  poly       in   poly_we            poly_wdata (reflected polynomial)
//
//  One transfer per clock when not stalled or building; stages s1, s2, s3, out.
//  The remainder loop closes in the last stage: one 32x32 GF(2) matrix product
//  selected by the byte count, plus the merged lane term.
//  After reset and after every polynomial write the builder makes A_1 to A_n
//  (n = BYTES_PER_ITEM, 8 by default); items.ready is low meanwhile.
//  A stall on results backs up stage by stage; empty stages still fill.
//
module crc32_reflected_multi_byte_core #(
	parameter int BYTES_PER_ITEM = crc32rm_pkg::DEF_BYTES_PER_ITEM
) (
	input  logic                   clk,
	input  logic                   arst_n,
	crc32rm_item_if.sink           items,
	crc32rm_result_if.source       results,
	input  logic                   poly_we,
	input  logic [31:0]            poly_wdata
);
	import crc32rm_pkg::*;

	localparam int LW = 8 * BYTES_PER_ITEM;

	// advance matrices A_0..A_n, A_n = effect of n zero bytes
	crc_mat_t         mats [BYTES_PER_ITEM+1];
	logic             busy;

	// pipeline occupancy
	logic             s1_v, s2_v, s3_v, out_v;
	logic             s1_free, s2_free, s3_free, out_free;
	logic             accept, load_s2, load_s3, load_out;

	logic [CNT_W-1:0] cnt_sat;
	logic [CNT_W-1:0] pad;
	logic [LW-1:0]    aligned;
	logic [LW-1:0]    lanes_s1;
	item_ctrl_t       ctrl_s1, ctrl_s2, ctrl_s3;
	crc_t             lane_c [BYTES_PER_ITEM];

	// stage handshake: a stage takes new data if empty or draining
	assign out_free = !out_v || results.ready;
	assign s3_free  = !s3_v || out_free;
	assign s2_free  = !s2_v || s3_free;
	assign s1_free  = !s1_v || s2_free;

	assign items.ready = s1_free && !busy;
	assign accept      = items.valid && items.ready;
	assign load_s2     = s1_v && s2_free;
	assign load_s3     = s2_v && s3_free;
	assign load_out    = s3_v && out_free;

	// count saturates to lane count
	assign cnt_sat = (CNT_W'(items.byte_count) > CNT_W'(BYTES_PER_ITEM))
		? CNT_W'(BYTES_PER_ITEM) : CNT_W'(items.byte_count);

	// right-align the valid bytes so the last byte sits in the top lane;
	// leading zero bytes on a zero start contribute nothing
	assign pad     = CNT_W'(BYTES_PER_ITEM) - cnt_sat;
	assign aligned = LW'(items.data_bytes) << {pad, 3'b000};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_v  <= 1'b0;
			s2_v  <= 1'b0;
			s3_v  <= 1'b0;
			out_v <= 1'b0;
		end else begin
			if (s1_free) begin
				s1_v <= accept;
			end
			if (s2_free) begin
				s2_v <= s1_v;
			end
			if (s3_free) begin
				s3_v <= s2_v;
			end
			if (out_free) begin
				out_v <= s3_v;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			lanes_s1 <= aligned;
			ctrl_s1  <= '{first: items.first_item, last: items.last_item, count: cnt_sat};
		end
		if (load_s2) begin
			ctrl_s2 <= ctrl_s1;
		end
		if (load_s3) begin
			ctrl_s3 <= ctrl_s2;
		end
	end

	crc32rm_mtx_gen #(
		.BYTES_PER_ITEM(BYTES_PER_ITEM)
	) u_mtx_gen (
		.clk       (clk),
		.arst_n    (arst_n),
		.poly_we   (poly_we),
		.poly_wdata(poly_wdata),
		.mats      (mats),
		.busy      (busy)
	);

	// lane j carries a byte followed by BYTES_PER_ITEM-1-j more bytes
	for (genvar j = 0; j < BYTES_PER_ITEM; j++) begin : g_lane
		crc32rm_lane u_lane (
			.clk       (clk),
			.load      (load_s2),
			.mat       (mats[BYTES_PER_ITEM - j]),
			.lane_byte (lanes_s1[8*j +: 8]),
			.contrib_s2(lane_c[j])
		);
	end

	crc32rm_merge #(
		.BYTES_PER_ITEM(BYTES_PER_ITEM)
	) u_merge (
		.clk              (clk),
		.arst_n           (arst_n),
		.lane_c           (lane_c),
		.load_s3          (load_s3),
		.load_out         (load_out),
		.ctrl_s3          (ctrl_s3),
		.mats             (mats),
		.running_remainder(results.running_remainder),
		.final_crc        (results.final_crc),
		.is_final         (results.is_final)
	);

	assign results.valid = out_v;

`ifndef SYNTHESIS
	a_build_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		busy |-> !items.ready)
		else $error("input accepted while matrices are being built");

	a_accept_fills_s1: assert property (@(posedge clk) disable iff (!arst_n)
		(items.valid && items.ready) |=> s1_v)
		else $error("accepted transfer did not enter stage 1");

	a_s3_held_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(s3_v && out_v && !results.ready) |=> s3_v)
		else $error("stage 3 item lost during output stall");
`endif

endmodule
